[sv/euler_yxz_view_matrix_top_defines.svh]
// assertion macros shared by the view matrix rtl
`ifndef EULER_YXZ_VIEW_MATRIX_TOP_DEFINES_SVH
`define EULER_YXZ_VIEW_MATRIX_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define EYVM_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define EYVM_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/eyvm_pkg.sv]
// shared constants, types and tables for the view matrix pipeline
`default_nettype none

package eyvm_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int BASIS_FRAC_DEF = 14;
    localparam int POS_W          = 32;
    localparam int TRANS_W        = 34;

    localparam logic [30:0] PIH_Q30 = 31'h6487ED51;
    localparam logic [30:0] ONE_Q30 = 31'h40000000;

    localparam longint TRANS_MAX = 64'sd8589934591;
    localparam longint TRANS_MIN = -64'sd8589934592;

    localparam int N_TAYLOR = 6;

    // pipeline depths of the three units
    localparam int SIN_LAT   = 3 + 3 * N_TAYLOR;
    localparam int BASIS_LAT = 3;
    localparam int TRANS_LAT = 3;

    typedef enum logic [1:0] {
        QUAD_I,
        QUAD_II,
        QUAD_III,
        QUAD_IV
    } quad_t;

    // series divisors, innermost term first
    function automatic logic [7:0] div_const(input int idx);
        logic [7:0] k;
        unique case (idx)
            0:       k = 8'd156;
            1:       k = 8'd110;
            2:       k = 8'd72;
            3:       k = 8'd42;
            4:       k = 8'd20;
            default: k = 8'd6;
        endcase
        return k;
    endfunction

    // floor(2^shift / k), fits in 32 bits
    function automatic logic [31:0] div_magic(input int idx);
        logic [31:0] m;
        unique case (idx)
            0:       m = 32'd3524075730;
            1:       m = 32'd2498890063;
            2:       m = 32'd3817748707;
            3:       m = 32'd3272356035;
            4:       m = 32'd3435973836;
            default: m = 32'd2863311530;
        endcase
        return m;
    endfunction

    function automatic int div_shift(input int idx);
        int s;
        unique case (idx)
            0:       s = 39;
            1:       s = 38;
            2:       s = 38;
            3:       s = 37;
            4:       s = 36;
            default: s = 34;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

[sv/euler_yxz_view_matrix_top.sv]
// top level of the yaw-pitch-roll camera view matrix pipeline
`default_nettype none

// One camera pose (Q16.16 position, three binary angles) enters per cycle and
// leaves as one word holding the Q1.14 right/up/forward basis and the Q17.16
// view translation. The pose passes through the sine units (six series
// terms, three stages each, around a 32x32 multiply and a reciprocal divide),
// then the basis products, then the dot products and rounding. Six sine
// units run in parallel, a sine and a cosine for each angle. Valid bits ride
// with the data; while the output word is held by out_stall the whole
// pipeline freezes and in_stall is raised, otherwise a word is taken every
// cycle, bubbles included. Rotation order is yaw (angle_y), then pitch
// (angle_x), then roll (angle_z). No reset-time init; ready right away.

`include "euler_yxz_view_matrix_top_defines.svh"

module euler_yxz_view_matrix_top
    import eyvm_pkg::*;
#(
    parameter int ANGLE_BITS      = ANGLE_BITS_DEF,
    parameter int BASIS_FRAC_BITS = BASIS_FRAC_DEF
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic signed [POS_W-1:0]           pos_x,
    input  wire logic signed [POS_W-1:0]           pos_y,
    input  wire logic signed [POS_W-1:0]           pos_z,
    input  wire logic        [ANGLE_BITS-1:0]      angle_x,
    input  wire logic        [ANGLE_BITS-1:0]      angle_y,
    input  wire logic        [ANGLE_BITS-1:0]      angle_z,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed      [BASIS_FRAC_BITS+1:0] right_x,
    output logic signed      [BASIS_FRAC_BITS+1:0] right_y,
    output logic signed      [BASIS_FRAC_BITS+1:0] right_z,
    output logic signed      [BASIS_FRAC_BITS+1:0] upv_x,
    output logic signed      [BASIS_FRAC_BITS+1:0] upv_y,
    output logic signed      [BASIS_FRAC_BITS+1:0] upv_z,
    output logic signed      [BASIS_FRAC_BITS+1:0] fwd_x,
    output logic signed      [BASIS_FRAC_BITS+1:0] fwd_y,
    output logic signed      [BASIS_FRAC_BITS+1:0] fwd_z,
    output logic signed      [TRANS_W-1:0]         trans_u,
    output logic signed      [TRANS_W-1:0]         trans_v,
    output logic signed      [TRANS_W-1:0]         trans_w
);

    localparam int F     = BASIS_FRAC_BITS;
    localparam int LAT   = SIN_LAT + BASIS_LAT + TRANS_LAT;
    localparam int PDLY  = SIN_LAT + BASIS_LAT;
    localparam logic [ANGLE_BITS-2:0] QTR = (ANGLE_BITS-1)'(1) << (ANGLE_BITS - 2);
    localparam logic signed [F+1:0] B_ONE = (F+2)'(1) << F;
    localparam logic signed [F+1:0] B_NEG = -B_ONE;

    // one valid bit per stage; the whole pipe advances together
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;
    logic           adv;

    assign in_stall  = vld_reg[LAT-1] & out_stall;
    assign adv       = ~in_stall;
    assign out_valid = vld_reg[LAT-1];
    assign vld_next  = {vld_reg[LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    // angles in basis order: yaw, pitch, roll
    logic [ANGLE_BITS-1:0] ang [3];
    assign ang[0] = angle_y;
    assign ang[1] = angle_x;
    assign ang[2] = angle_z;

    logic [F:0] s_lo [3];
    logic [F:0] s_hi [3];
    quad_t      quad_d [3];

    for (genvar a = 0; a < 3; a++)
    begin : g_angle
        logic [ANGLE_BITS-2:0] n_lo;
        logic [ANGLE_BITS-2:0] n_hi;
        quad_t                 quad_reg [SIN_LAT];

        // offset within the quadrant and its complement
        assign n_lo = {1'b0, ang[a][ANGLE_BITS-3:0]};
        assign n_hi = QTR - n_lo;

        eyvm_sine #(
            .ANGLE_BITS      (ANGLE_BITS),
            .BASIS_FRAC_BITS (BASIS_FRAC_BITS)
        ) u_sin_lo (
            .clk  (clk),
            .en   (adv),
            .n    (n_lo),
            .sine (s_lo[a])
        );

        eyvm_sine #(
            .ANGLE_BITS      (ANGLE_BITS),
            .BASIS_FRAC_BITS (BASIS_FRAC_BITS)
        ) u_sin_hi (
            .clk  (clk),
            .en   (adv),
            .n    (n_hi),
            .sine (s_hi[a])
        );

        // quadrant rides alongside the sine units
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                quad_reg[0] <= quad_t'(ang[a][ANGLE_BITS-1:ANGLE_BITS-2]);
                for (int i = 1; i < SIN_LAT; i++)
                begin
                    quad_reg[i] <= quad_reg[i-1];
                end
            end
        end

        assign quad_d[a] = quad_reg[SIN_LAT-1];
    end

    // position waits for the basis
    logic signed [POS_W-1:0] px_reg [PDLY];
    logic signed [POS_W-1:0] py_reg [PDLY];
    logic signed [POS_W-1:0] pz_reg [PDLY];
    logic signed [POS_W-1:0] pos_d  [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg[0] <= pos_x;
            py_reg[0] <= pos_y;
            pz_reg[0] <= pos_z;
            for (int i = 1; i < PDLY; i++)
            begin
                px_reg[i] <= px_reg[i-1];
                py_reg[i] <= py_reg[i-1];
                pz_reg[i] <= pz_reg[i-1];
            end
        end
    end

    assign pos_d[0] = px_reg[PDLY-1];
    assign pos_d[1] = py_reg[PDLY-1];
    assign pos_d[2] = pz_reg[PDLY-1];

    logic signed [F+1:0]        basis [9];
    logic signed [F+1:0]        m_out [9];
    logic signed [TRANS_W-1:0]  trans [3];

    eyvm_basis #(
        .BASIS_FRAC_BITS (BASIS_FRAC_BITS)
    ) u_basis (
        .clk  (clk),
        .en   (adv),
        .s_lo (s_lo),
        .s_hi (s_hi),
        .quad (quad_d),
        .m    (basis)
    );

    eyvm_trans #(
        .BASIS_FRAC_BITS (BASIS_FRAC_BITS)
    ) u_trans (
        .clk   (clk),
        .en    (adv),
        .m_in  (basis),
        .pos   (pos_d),
        .m_out (m_out),
        .trans (trans)
    );

    // output word straight from the last stage registers
    assign right_x = m_out[0];
    assign right_y = m_out[1];
    assign right_z = m_out[2];
    assign upv_x   = m_out[3];
    assign upv_y   = m_out[4];
    assign upv_z   = m_out[5];
    assign fwd_x   = m_out[6];
    assign fwd_y   = m_out[7];
    assign fwd_z   = m_out[8];
    assign trans_u = trans[0];
    assign trans_v = trans[1];
    assign trans_w = trans[2];

    // frozen pipe keeps every valid bit
    `EYVM_ASSERT_NEXT(a_freeze_holds, clk, rst_n, !adv, $stable(vld_reg), "valid bits moved while frozen")
    // input is only held back by a waiting output word
    `EYVM_ASSERT_NOW(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall, "input stalled without cause")
    // right_x and fwd_z stay within one
    `EYVM_ASSERT_NOW(a_right_range, clk, rst_n, out_valid, right_x <= B_ONE && right_x >= B_NEG, "right_x out of range")
    `EYVM_ASSERT_NOW(a_fwd_range, clk, rst_n, out_valid, fwd_z <= B_ONE && fwd_z >= B_NEG, "fwd_z out of range")

endmodule

`default_nettype wire

[sv/eyvm_sine.sv]
// first-quadrant sine unit, one term of the series every three stages
`default_nettype none

module eyvm_sine
    import eyvm_pkg::*;
#(
    parameter int ANGLE_BITS      = ANGLE_BITS_DEF,
    parameter int BASIS_FRAC_BITS = BASIS_FRAC_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic [ANGLE_BITS-2:0]    n,
    output logic      [BASIS_FRAC_BITS:0] sine
);

    localparam int NW = ANGLE_BITS - 1;
    localparam int F  = BASIS_FRAC_BITS;

    logic [NW+30:0] xp;
    logic [30:0]    x_reg;
    logic [61:0]    xx;
    logic [30:0]    x1_reg;
    logic [31:0]    x2_reg;

    logic [30:0] xc  [N_TAYLOR+1];
    logic [31:0] x2c [N_TAYLOR+1];
    logic [30:0] tc  [N_TAYLOR+1];

    // angle offset scaled to radians
    assign xp = {{31{1'b0}}, n} * {{NW{1'b0}}, PIH_Q30};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= xp[ANGLE_BITS-2 +: 31];
        end
    end

    assign xx = {31'b0, x_reg} * {31'b0, x_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg <= x_reg;
            x2_reg <= xx[30 +: 32];
        end
    end

    assign xc[0]  = x1_reg;
    assign x2c[0] = x2_reg;
    assign tc[0]  = ONE_Q30;

    for (genvar g = 0; g < N_TAYLOR; g++)
    begin : g_term
        localparam logic [31:0] M  = div_magic(g);
        localparam int          SH = div_shift(g);
        localparam logic [7:0]  K  = div_const(g);

        logic [30:0] ax_reg, bx_reg, cx_reg;
        logic [31:0] ax2_reg, bx2_reg, cx2_reg;
        logic [62:0] p_reg;
        logic [31:0] y_reg;
        logic [63:0] prod_reg;
        logic [30:0] t_reg;
        logic [31:0] y_next;
        logic [63:0] qs;
        logic [31:0] q;
        logic [39:0] qk;
        logic [39:0] rem;
        logic [31:0] qf;

        assign y_next = p_reg[30 +: 32];
        assign qs     = prod_reg >> SH;
        assign q      = qs[31:0];
        assign qk     = {8'b0, q} * {32'b0, K};
        assign rem    = {8'b0, y_reg} - qk;
        // reciprocal estimate is at most one low
        assign qf     = (rem >= {32'b0, K}) ? q + 32'd1 : q;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p_reg    <= {31'b0, x2c[g]} * {32'b0, tc[g]};
                ax_reg   <= xc[g];
                ax2_reg  <= x2c[g];
                y_reg    <= y_next;
                prod_reg <= {32'b0, y_next} * {32'b0, M};
                bx_reg   <= ax_reg;
                bx2_reg  <= ax2_reg;
                t_reg    <= ONE_Q30 - qf[30:0];
                cx_reg   <= bx_reg;
                cx2_reg  <= bx2_reg;
            end
        end

        assign xc[g+1]  = cx_reg;
        assign x2c[g+1] = cx2_reg;
        assign tc[g+1]  = t_reg;
    end

    logic [61:0] st;
    logic [31:0] s;
    logic [30:0] sc;
    logic [F:0]  sine_next;
    logic [F:0]  sine_reg;

    assign st = {31'b0, xc[N_TAYLOR]} * {31'b0, tc[N_TAYLOR]};
    assign s  = st[30 +: 32];
    assign sc = (s > {1'b0, ONE_Q30}) ? ONE_Q30 : s[30:0];

    if (F >= 30)
    begin : g_full
        assign sine_next = sc[F:0];
    end
    else
    begin : g_round
        localparam logic [31:0] HALF = 32'd1 << (29 - F);
        logic [31:0] rs;
        assign rs        = ({1'b0, sc} + HALF) >> (30 - F);
        assign sine_next = rs[F:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sine_reg <= sine_next;
        end
    end

    assign sine = sine_reg;

endmodule

`default_nettype wire

[sv/eyvm_basis.sv]
// sine/cosine unfolding and basis products
`default_nettype none

module eyvm_basis
    import eyvm_pkg::*;
#(
    parameter int BASIS_FRAC_BITS = BASIS_FRAC_DEF
)
(
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic        [BASIS_FRAC_BITS:0]   s_lo [3],
    input  wire logic        [BASIS_FRAC_BITS:0]   s_hi [3],
    input  wire quad_t                             quad [3],
    output logic signed      [BASIS_FRAC_BITS+1:0] m    [9]
);

    localparam int F = BASIS_FRAC_BITS;
    localparam logic signed [2*F+3:0] MHALF = (2*F+4)'(1) << (F - 1);
    localparam logic signed [F+2:0]   B_ONE = (F+3)'(1) << F;
    localparam logic signed [F+2:0]   B_NEG = -B_ONE;

    function automatic logic signed [F+1:0] mulf(input logic signed [F+1:0] a,
                                                input logic signed [F+1:0] b);
        logic signed [2*F+3:0] p;
        p = $signed({{(F+2){a[F+1]}}, a}) * $signed({{(F+2){b[F+1]}}, b});
        p = (p + MHALF) >>> F;
        return p[F+1:0];
    endfunction

    function automatic logic signed [F+1:0] sat(input logic signed [F+2:0] v);
        logic signed [F+2:0] r;
        r = v;
        if (v > B_ONE)
            r = B_ONE;
        else if (v < B_NEG)
            r = B_NEG;
        return r[F+1:0];
    endfunction

    logic signed [F+1:0] sn [3];
    logic signed [F+1:0] cs [3];

    // unfold quadrant: index 0 yaw, 1 pitch, 2 roll
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            unique case (quad[i])
                QUAD_I:
                begin
                    sn[i] = $signed({1'b0, s_lo[i]});
                    cs[i] = $signed({1'b0, s_hi[i]});
                end
                QUAD_II:
                begin
                    sn[i] = $signed({1'b0, s_hi[i]});
                    cs[i] = -$signed({1'b0, s_lo[i]});
                end
                QUAD_III:
                begin
                    sn[i] = -$signed({1'b0, s_lo[i]});
                    cs[i] = -$signed({1'b0, s_hi[i]});
                end
                default:
                begin
                    sn[i] = -$signed({1'b0, s_hi[i]});
                    cs[i] = $signed({1'b0, s_lo[i]});
                end
            endcase
        end
    end

    logic signed [F+1:0] c1c3_reg, s1s2_reg, c2s3_reg, c1s2_reg, c3s1_reg;
    logic signed [F+1:0] c1s3_reg, c2c3_reg, s1s3_reg, c2s1_reg, c1c2_reg;
    logic signed [F+1:0] s2_reg, s3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1c3_reg <= mulf(cs[0], cs[2]);
            s1s2_reg <= mulf(sn[0], sn[1]);
            c2s3_reg <= mulf(cs[1], sn[2]);
            c1s2_reg <= mulf(cs[0], sn[1]);
            c3s1_reg <= mulf(cs[2], sn[0]);
            c1s3_reg <= mulf(cs[0], sn[2]);
            c2c3_reg <= mulf(cs[1], cs[2]);
            s1s3_reg <= mulf(sn[0], sn[2]);
            c2s1_reg <= mulf(cs[1], sn[0]);
            c1c2_reg <= mulf(cs[0], cs[1]);
            s2_reg   <= sn[1];
            s3_reg   <= sn[2];
        end
    end

    logic signed [F+1:0] s1s2s3_reg, c1s2s3_reg, c3s1s2_reg, c1c3s2_reg;
    logic signed [F+1:0] c1c3_d_reg, c2s3_d_reg, c3s1_d_reg, c1s3_d_reg;
    logic signed [F+1:0] c2c3_d_reg, s1s3_d_reg, c2s1_d_reg, c1c2_d_reg, s2_d_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1s2s3_reg <= mulf(s1s2_reg, s3_reg);
            c1s2s3_reg <= mulf(c1s2_reg, s3_reg);
            c3s1s2_reg <= mulf(c3s1_reg, s2_reg);
            c1c3s2_reg <= mulf(c1c3_reg, s2_reg);
            c1c3_d_reg <= c1c3_reg;
            c2s3_d_reg <= c2s3_reg;
            c3s1_d_reg <= c3s1_reg;
            c1s3_d_reg <= c1s3_reg;
            c2c3_d_reg <= c2c3_reg;
            s1s3_d_reg <= s1s3_reg;
            c2s1_d_reg <= c2s1_reg;
            c1c2_d_reg <= c1c2_reg;
            s2_d_reg   <= s2_reg;
        end
    end

    logic signed [F+2:0] sum [9];
    logic signed [F+1:0] m_reg [9];

    always_comb
    begin
        sum[0] = (F+3)'(c1c3_d_reg) + (F+3)'(s1s2s3_reg);
        sum[1] = (F+3)'(c2s3_d_reg);
        sum[2] = (F+3)'(c1s2s3_reg) - (F+3)'(c3s1_d_reg);
        sum[3] = (F+3)'(c3s1s2_reg) - (F+3)'(c1s3_d_reg);
        sum[4] = (F+3)'(c2c3_d_reg);
        sum[5] = (F+3)'(c1c3s2_reg) + (F+3)'(s1s3_d_reg);
        sum[6] = (F+3)'(c2s1_d_reg);
        sum[7] = -(F+3)'(s2_d_reg);
        sum[8] = (F+3)'(c1c2_d_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 9; i++)
            begin
                m_reg[i] <= sat(sum[i]);
            end
        end
    end

    assign m = m_reg;

endmodule

`default_nettype wire

[sv/eyvm_trans.sv]
// view translation: three dot products, rounding and clamp
`default_nettype none

module eyvm_trans
    import eyvm_pkg::*;
#(
    parameter int BASIS_FRAC_BITS = BASIS_FRAC_DEF
)
(
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic signed [BASIS_FRAC_BITS+1:0] m_in  [9],
    input  wire logic signed [POS_W-1:0]           pos   [3],
    output logic signed      [BASIS_FRAC_BITS+1:0] m_out [9],
    output logic signed      [TRANS_W-1:0]         trans [3]
);

    localparam int F  = BASIS_FRAC_BITS;
    localparam int PW = F + 2 + POS_W;
    localparam int DW = PW + 2;
    localparam int NW = DW + 1;
    localparam logic signed [NW-1:0] RHALF = NW'(1) << (F - 1);
    localparam logic signed [NW-1:0] T_MAX = NW'(TRANS_MAX);
    localparam logic signed [NW-1:0] T_MIN = NW'(TRANS_MIN);

    logic signed [PW-1:0]  pr_reg  [9];
    logic signed [F+1:0]   m0_reg  [9];
    logic signed [DW-1:0]  dot_reg [3];
    logic signed [F+1:0]   m1_reg  [9];
    logic signed [TRANS_W-1:0] t_reg [3];
    logic signed [F+1:0]   m2_reg  [9];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 9; i++)
            begin
                pr_reg[i] <= PW'(m_in[i]) * PW'(pos[i % 3]);
                m0_reg[i] <= m_in[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                dot_reg[r] <= DW'(pr_reg[3*r]) + DW'(pr_reg[3*r+1]) + DW'(pr_reg[3*r+2]);
            end
            m1_reg <= m0_reg;
        end
    end

    logic signed [NW-1:0] tq [3];

    // negate, round half up, saturate to the output range
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            tq[r] = (-NW'(dot_reg[r]) + RHALF) >>> F;
            if (tq[r] > T_MAX)
                tq[r] = T_MAX;
            else if (tq[r] < T_MIN)
                tq[r] = T_MIN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                t_reg[r] <= tq[r][TRANS_W-1:0];
            end
            m2_reg <= m1_reg;
        end
    end

    assign m_out = m2_reg;
    assign trans = t_reg;

endmodule

`default_nettype wire

[dv/euler_yxz_view_matrix_top_tb.sv]
// testbench for the yaw-pitch-roll camera view matrix pipeline
`timescale 1ns / 100ps

module euler_yxz_view_matrix_top_tb;
    import eyvm_pkg::*;

    localparam int AB = ANGLE_BITS_DEF;
    localparam int FB = BASIS_FRAC_DEF;
    localparam int BW = FB + 2;
    localparam int PIPE_DEPTH = SIN_LAT + BASIS_LAT + TRANS_LAT;

    typedef struct {
        logic signed [POS_W-1:0] px, py, pz;
        logic [AB-1:0] ax, ay, az;
    } pose_t;

    typedef struct {
        logic signed [BW-1:0] m [9];
        logic signed [TRANS_W-1:0] t [3];
    } view_t;

    int mismatches = 0;

    // one line per mismatch, counted
    task automatic report(input string what, input longint got, input longint want);
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // floor((v + half) / 2^sh)
    function automatic longint rnd_shift(input longint v, input int sh);
        return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function automatic longint quarter_sine(input longint n);
        longint unsigned x, x2, t, s;
        longint unsigned divs [6] = '{156, 110, 72, 42, 20, 6};
        x = (longint'(n) * longint'(PIH_Q30)) >> (AB - 2);
        x2 = (x * x) >> 30;
        t = longint'(ONE_Q30);
        for (int i = 0; i < 6; i++)
            t = longint'(ONE_Q30) - (((x2 * t) >> 30) / divs[i]);
        s = (x * t) >> 30;
        if (s > longint'(ONE_Q30))
            s = longint'(ONE_Q30);
        return rnd_shift(longint'(s), 30 - FB);
    endfunction

    function automatic void angle_sin_cos(input logic [AB-1:0] a, output longint sn,
                                          output longint cs);
        longint qs, r, sr, sc;
        quad_t quad;
        qs = longint'(1) << (AB - 2);
        quad = quad_t'(a[AB-1:AB-2]);
        r = a[AB-3:0];
        sr = quarter_sine(r);
        sc = quarter_sine(qs - r);
        case (quad)
            QUAD_I:   begin sn = sr;  cs = sc;  end
            QUAD_II:  begin sn = sc;  cs = -sr; end
            QUAD_III: begin sn = -sr; cs = -sc; end
            default:  begin sn = -sc; cs = sr;  end
        endcase
    endfunction

    function automatic longint fmul(input longint a, input longint b);
        return rnd_shift(a * b, FB);
    endfunction

    // expected basis and translation for one pose
    function automatic view_t view_of(input pose_t p);
        view_t v;
        longint s1, c1, s2, c2, s3, c3, one, d, tr;
        longint m [9];
        longint pos [3];
        angle_sin_cos(p.ay, s1, c1);
        angle_sin_cos(p.ax, s2, c2);
        angle_sin_cos(p.az, s3, c3);
        pos[0] = p.px; pos[1] = p.py; pos[2] = p.pz;
        m[0] = fmul(c1, c3) + fmul(fmul(s1, s2), s3);
        m[1] = fmul(c2, s3);
        m[2] = fmul(fmul(c1, s2), s3) - fmul(c3, s1);
        m[3] = fmul(fmul(c3, s1), s2) - fmul(c1, s3);
        m[4] = fmul(c2, c3);
        m[5] = fmul(fmul(c1, c3), s2) + fmul(s1, s3);
        m[6] = fmul(c2, s1);
        m[7] = -s2;
        m[8] = fmul(c1, c2);
        one = longint'(1) << FB;
        for (int i = 0; i < 9; i++) begin
            if (m[i] > one) m[i] = one;
            if (m[i] < -one) m[i] = -one;
            v.m[i] = m[i][BW-1:0];
        end
        for (int i = 0; i < 3; i++) begin
            d = m[3*i] * pos[0] + m[3*i+1] * pos[1] + m[3*i+2] * pos[2];
            tr = rnd_shift(-d, FB);
            if (tr > TRANS_MAX) tr = TRANS_MAX;
            if (tr < TRANS_MIN) tr = TRANS_MIN;
            v.t[i] = tr[TRANS_W-1:0];
        end
        return v;
    endfunction

    class view_scoreboard;
        view_t pending [$];

        function void note_pose(pose_t p);
            pending.push_back(view_of(p));
        endfunction

        task check_view(view_t got);
            view_t want;
            string names [9] = '{"right_x", "right_y", "right_z", "upv_x", "upv_y",
                                 "upv_z", "fwd_x", "fwd_y", "fwd_z"};
            string tnames [3] = '{"trans_u", "trans_v", "trans_w"};
            if (pending.size() == 0) begin
                report("unexpected word", 0, 0);
                return;
            end
            want = pending.pop_front();
            for (int i = 0; i < 9; i++)
                if (got.m[i] !== want.m[i])
                    report(names[i], got.m[i], want.m[i]);
            for (int i = 0; i < 3; i++)
                if (got.t[i] !== want.t[i])
                    report(tnames[i], got.t[i], want.t[i]);
        endtask
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic out_stall = 0;
    logic signed [POS_W-1:0] pos_x = 0, pos_y = 0, pos_z = 0;
    logic [AB-1:0] angle_x = 0, angle_y = 0, angle_z = 0;
    wire in_stall, out_valid;
    wire signed [BW-1:0] right_x, right_y, right_z, upv_x, upv_y, upv_z;
    wire signed [BW-1:0] fwd_x, fwd_y, fwd_z;
    wire signed [TRANS_W-1:0] trans_u, trans_v, trans_w;

    euler_yxz_view_matrix_top DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .right_x(right_x), .right_y(right_y), .right_z(right_z),
        .upv_x(upv_x), .upv_y(upv_y), .upv_z(upv_z),
        .fwd_x(fwd_x), .fwd_y(fwd_y), .fwd_z(fwd_z),
        .trans_u(trans_u), .trans_v(trans_v), .trans_w(trans_w)
    );

    always #2 clk = ~clk;

    view_scoreboard board = new();

    // idling stops in the last part of the run
    bit calm = 0;
    // receiver long hold-off, raised once by the sender
    bit hold_request = 0;
    bit sending_done = 0;

    // accepted poses go to the scoreboard, accepted words get checked
    always @(posedge clk) begin
        pose_t p;
        view_t v;
        if (rst_n && in_valid && !in_stall) begin
            p.px = pos_x; p.py = pos_y; p.pz = pos_z;
            p.ax = angle_x; p.ay = angle_y; p.az = angle_z;
            board.note_pose(p);
        end
        if (rst_n && out_valid && !out_stall) begin
            v.m = '{right_x, right_y, right_z, upv_x, upv_y, upv_z, fwd_x, fwd_y, fwd_z};
            v.t = '{trans_u, trans_v, trans_w};
            board.check_view(v);
        end
    end

    // offer one pose and hold it until taken, with an occasional idle burst first
    task automatic send_pose(input pose_t p);
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1;
        pos_x <= p.px; pos_y <= p.py; pos_z <= p.pz;
        angle_x <= p.ax; angle_y <= p.ay; angle_z <= p.az;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(0, 65535 * 8) - 65536 * 4;
            default: return $urandom;
        endcase
    endfunction

    // angles near quadrant boundaries are the interesting ones
    function automatic logic [AB-1:0] rand_angle();
        logic [AB-1:0] a;
        a = AB'($urandom);
        if ($urandom_range(0, 3) == 0)
            a = AB'({a[AB-1:AB-2], {(AB-2){1'b0}}} + $urandom_range(0, 3) - 2);
        return a;
    endfunction

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        @(posedge rst_n);
        while (!sending_done) begin
            @(posedge clk);
            if (hold_request) begin
                hold_request = 0;
                out_stall <= 1;
                repeat (3 * PIPE_DEPTH) @(posedge clk);
                out_stall <= 0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                out_stall <= 1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                out_stall <= 0;
            end
        end
        out_stall <= 0;
    end

    initial begin
        pose_t p;
        int drain;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: zero pose, position extremes, every quadrant boundary
        for (int i = 0; i < 24; i++) begin
            p.px = (i % 3 == 0) ? 32'h8000_0000 : (i % 3 == 1) ? 32'h7fff_ffff : 0;
            p.py = (i % 2) ? 32'h8000_0000 : 32'h7fff_ffff;
            p.pz = (i % 4 == 0) ? 32'h8000_0000 : 32'h0001_0000;
            p.ax = AB'((i % 8) * (1 << (AB - 3)));
            p.ay = AB'(((i + 3) % 8) * (1 << (AB - 3)) + (i == 5 ? {AB{1'b1}} : 0));
            p.az = (i == 23) ? {AB{1'b1}} : AB'(((i * 5) % 8) * (1 << (AB - 3)));
            if (i == 0) begin
                p.px = 0; p.py = 0; p.pz = 0; p.ax = 0; p.ay = 0; p.az = 0;
            end
            send_pose(p);
        end

        for (int i = 0; i < 1600; i++) begin
            if (i == 300) hold_request = 1;
            if (i == 1300) calm = 1;
            p.px = rand_pos(); p.py = rand_pos(); p.pz = rand_pos();
            p.ax = rand_angle(); p.ay = rand_angle(); p.az = rand_angle();
            send_pose(p);
        end
        in_valid <= 0;
        sending_done = 1;

        drain = 0;
        while (board.pending.size() != 0 && drain < 100000) begin
            @(posedge clk);
            drain++;
        end
        repeat (PIPE_DEPTH + 10) @(posedge clk);
        if (mismatches == 0 && board.pending.size() == 0)
            $display("euler_yxz_view_matrix_top_tb OK");
        else
            $display("euler_yxz_view_matrix_top_tb NOT OK");
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("euler_yxz_view_matrix_top_tb NOT OK");
        $finish;
    end

endmodule
